// File: hw/rtl/lsi_pkg.sv
// lsi_pkg: shared types, filter taps and constants for the luma sub-pel interpolator
`timescale 1ns / 1ps
package lsi_pkg;

  localparam int TAPS     = 8;
  localparam int COLS     = 8;
  localparam int WIN_ROWS = 7;
  localparam int SRC_PIX  = COLS + TAPS - 1;

  // horizontal offset keeps intermediates inside int16
  localparam logic signed [17:0] H_OFFSET = 18'sd8192;
  // vertical offset plus rounding half of the final shift
  localparam logic signed [23:0] V_ROUND  = 24'sd526336;
  localparam int                 V_SHIFT  = 12;

  typedef logic signed [7:0]  coef_t;
  typedef logic signed [15:0] h_t;
  typedef h_t [COLS-1:0]      h_row_t;

  localparam coef_t LUMA_TAPS [4][TAPS] = '{
    '{ 8'sd0,  8'sd0,   8'sd0, 8'sd64,  8'sd0,   8'sd0,  8'sd0,  8'sd0},
    '{-8'sd1,  8'sd4, -8'sd10, 8'sd58, 8'sd17,  -8'sd5,  8'sd1,  8'sd0},
    '{-8'sd1,  8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11,  8'sd4, -8'sd1},
    '{ 8'sd0,  8'sd1,  -8'sd5, 8'sd17, 8'sd58, -8'sd10,  8'sd4, -8'sd1}
  };

  typedef struct packed {
    logic [55:0] pixels_hi;
    logic [63:0] pixels_lo;
    logic [1:0]  frac_x;
    logic [1:0]  frac_y;
  } in_t;

  typedef struct packed {
    logic [63:0] out_pixels;
    logic [2:0]  out_row;
    logic        last;
  } out_t;

  // per-row control carried down the pipeline
  typedef struct packed {
    logic [1:0] phase_y;
    logic       produce;
    logic       last;
    logic [2:0] row;
  } row_meta_t;

endpackage

// File: hw/rtl/lsi_hfilt.sv
// lsi_hfilt: horizontal 8-tap filter of one source row into eight int16 intermediates
`timescale 1ns / 1ps
module lsi_hfilt import lsi_pkg::*; (
  input  logic [SRC_PIX*8-1:0] src_i,
  input  logic [1:0]           phase_i,
  output h_row_t               h_o
);

  always_comb begin
    logic signed [17:0] acc;
    logic signed [17:0] coef;
    logic signed [17:0] px;
    logic signed [17:0] res;
    h_o = '0;
    for (int i = 0; i < COLS; i++) begin
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
        coef = 18'(LUMA_TAPS[phase_i][k]);
        px   = {10'b0, src_i[8*(i+k) +: 8]};
        acc  = acc + coef * px;
      end
      res    = acc - H_OFFSET;
      h_o[i] = res[15:0];
    end
  end

endmodule

// File: hw/rtl/lsi_vfilt.sv
// lsi_vfilt: vertical 8-tap filter over the row window, rounding and clamping to 8 bits
`timescale 1ns / 1ps
module lsi_vfilt import lsi_pkg::*; (
  input  h_row_t      win_i [WIN_ROWS],
  input  h_row_t      cur_i,
  input  logic [1:0]  phase_i,
  output logic [63:0] pix_o
);

  h_row_t col_rows [TAPS];

  always_comb begin
    for (int k = 0; k < WIN_ROWS; k++) begin
      col_rows[k] = win_i[k];
    end
    col_rows[TAPS-1] = cur_i;
  end

  always_comb begin
    logic signed [23:0] acc;
    logic signed [23:0] coef;
    logic signed [23:0] hv;
    logic signed [23:0] sum;
    pix_o = '0;
    for (int i = 0; i < COLS; i++) begin
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
        coef = 24'(LUMA_TAPS[phase_i][k]);
        hv   = 24'($signed(col_rows[k][i]));
        acc  = acc + coef * hv;
      end
      sum = acc + V_ROUND;
      // negative clamps to 0, anything at or above 256 after the shift to 255
      if (sum[23]) begin
        pix_o[8*i +: 8] = 8'd0;
      end else if (|sum[22:V_SHIFT+8]) begin
        pix_o[8*i +: 8] = 8'hff;
      end else begin
        pix_o[8*i +: 8] = sum[V_SHIFT +: 8];
      end
    end
  end

endmodule

// File: hw/rtl/luma_subpel_interp_8x8_2d.sv
// luma_subpel_interp_8x8_2d: top level of the separable 8-tap luma interpolator
`timescale 1ns / 1ps
// Usage: a block is fed as BLOCK_ROWS + 7 source rows of 15 pixels on the input
// channel (in_valid_i / in_ready_o / in_data_i). The first row of a block sets the
// horizontal and vertical phases; later rows ignore frac_x and frac_y.
// The first 7 rows of a block give no output. Each later row gives one output
// row of 8 pixels on the output channel (out_valid_o / out_ready_i / out_data_o),
// with its row index and last set on the final row of the block.
// Pipeline: an accepted row passes the input register, the horizontal result
// register and the output register in that order.
// Throughput: one row per cycle while the output is not stalled; the horizontal
// and vertical filter stages each fit between a pair of registers, so nothing iterates.
// Stall: while out_ready_i is low a held output blocks only rows that produce a
// result; rows of the block head still drain into the window. in_ready_o drops
// once the pipeline is full behind a stalled output.
// Reset: the row counter and phases return to zero and the pipeline empties, so
// the next accepted row starts a new block. The row window has no reset; it is
// always filled before a result reads it.
module luma_subpel_interp_8x8_2d import lsi_pkg::*; #(
  parameter int BLOCK_ROWS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int CNT_W = $clog2(BLOCK_ROWS + WIN_ROWS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_ROWS + WIN_ROWS - 1);
  localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WIN_ROWS);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       phx_q, phx_d, phy_q, phy_d;

  logic                 a_valid_q, a_valid_d;
  logic [SRC_PIX*8-1:0] a_pix_q;
  logic [1:0]           a_px_q;
  row_meta_t            a_meta_q;

  logic      b_valid_q, b_valid_d;
  h_row_t    b_h_q;
  row_meta_t b_meta_q;

  h_row_t win_q [WIN_ROWS];

  logic out_valid_q, out_valid_d;
  out_t out_q;

  logic             in_fire, a_fire, b_fire, b_free, c_free;
  logic [1:0]       cur_px;
  logic [CNT_W-1:0] orow;
  row_meta_t        in_meta;
  h_row_t           h_row;
  logic [63:0]      v_pix;

  // pipeline flow: a non-producing row never waits on the output register
  assign c_free     = !out_valid_q || out_ready_i;
  assign b_fire     = b_valid_q && (!b_meta_q.produce || c_free);
  assign b_free     = !b_valid_q || b_fire;
  assign a_fire     = a_valid_q && b_free;
  assign in_ready_o = !a_valid_q || a_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cur_px = (cnt_q == '0) ? in_data_i.frac_x : phx_q;
  assign orow   = cnt_q - WIN_CNT;

  always_comb begin
    in_meta.phase_y = (cnt_q == '0) ? in_data_i.frac_y : phy_q;
    in_meta.produce = (cnt_q >= WIN_CNT);
    in_meta.last    = (cnt_q == LAST_CNT);
    in_meta.row     = orow[2:0];
  end

  always_comb begin
    cnt_d = cnt_q;
    phx_d = phx_q;
    phy_d = phy_q;
    if (in_fire) begin
      if (cnt_q == '0) begin
        phx_d = in_data_i.frac_x;
        phy_d = in_data_i.frac_y;
      end
      cnt_d = (cnt_q == LAST_CNT) ? '0 : cnt_q + 1'b1;
    end
  end

  always_comb begin
    a_valid_d = in_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_q);
    b_valid_d = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_q);
    if (b_fire && b_meta_q.produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  lsi_hfilt u_hfilt (
    .src_i   (a_pix_q),
    .phase_i (a_px_q),
    .h_o     (h_row)
  );

  lsi_vfilt u_vfilt (
    .win_i   (win_q),
    .cur_i   (b_h_q),
    .phase_i (b_meta_q.phase_y),
    .pix_o   (v_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      phx_q       <= '0;
      phy_q       <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      phx_q       <= phx_d;
      phy_q       <= phy_d;
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pix_q  <= {in_data_i.pixels_hi, in_data_i.pixels_lo};
      a_px_q   <= cur_px;
      a_meta_q <= in_meta;
    end
    if (a_fire) begin
      b_h_q    <= h_row;
      b_meta_q <= a_meta_q;
    end
    // window moves on as each row leaves the horizontal result register
    if (b_fire) begin
      for (int k = 0; k < WIN_ROWS - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[WIN_ROWS-1] <= b_h_q;
    end
    if (b_fire && b_meta_q.produce) begin
      out_q.out_pixels <= v_pix;
      out_q.out_row    <= b_meta_q.row;
      out_q.last       <= b_meta_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/lsi_checker.sv
// lsi_checker: port-level assertions for the luma interpolator, bound to the top level
`timescale 1ns / 1ps
module lsi_checker import lsi_pkg::*; #(
  parameter int BLOCK_ROWS = 8
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  localparam logic [2:0] LAST_ROW = 3'(BLOCK_ROWS - 1);

  logic [2:0] exp_row_q;
  logic       out_fire;
  logic       in_fire;

  assign out_fire = out_valid_o && out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  // expected index of the next output row, restarting after each last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= '0;
    end else if (out_fire) begin
      exp_row_q <= out_data_o.last ? 3'd0 : out_data_o.out_row + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_row == exp_row_q)
    else $error("output row index out of sequence");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.out_row == LAST_ROW)
    else $error("last flag on wrong output row");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o || !$past(in_fire))
    else $error("input stalled with no output pending");

endmodule

bind luma_subpel_interp_8x8_2d lsi_checker #(.BLOCK_ROWS(BLOCK_ROWS)) u_lsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
